>>> design/rwts_pkg.sv
// Shared constants, types and helpers for the random-walk transition block.
package rwts_pkg;

    localparam int unsigned MaxNodes     = 1024;
    localparam int unsigned MaxEdgeSlots = 8192;
    localparam int unsigned NodeW        = $clog2(MaxNodes);
    localparam int unsigned SlotW        = $clog2(MaxEdgeSlots);
    localparam int unsigned CountW       = 11;
    localparam int unsigned MassW        = 32;
    localparam int unsigned DegW         = 10;
    localparam int unsigned KindW        = 3;
    localparam int unsigned IndexW       = 13;
    localparam int unsigned RowW         = SlotW + DegW;

    localparam logic [KindW-1:0] KindLoadRow  = 3'd0;
    localparam logic [KindW-1:0] KindLoadNbr  = 3'd1;
    localparam logic [KindW-1:0] KindLoadMass = 3'd2;
    localparam logic [KindW-1:0] KindStep     = 3'd3;
    localparam logic [KindW-1:0] KindRead     = 3'd4;

    localparam logic [MassW-1:0] MassMax = '1;

    // Divider interface between the walker and the divide unit.
    typedef struct packed {
        logic             start;
        logic [MassW-1:0] dividend;
        logic [DegW-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [MassW-1:0] quotient;
    } t_div_rsp;

    function automatic logic [MassW-1:0] sat_add(input logic [MassW-1:0] a,
                                                 input logic [MassW-1:0] b);
        logic [MassW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[MassW] ? MassMax : s[MassW-1:0];
    endfunction

endpackage

>>> design/rwts_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
module rwts_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/rwts_div.sv
// Restoring divider: 32-bit mass by 10-bit degree, one quotient bit a cycle.
module rwts_div
    import rwts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [MassW-1:0]         r_quo, n_quo;
    logic [DegW:0]            r_rem, n_rem;
    logic [DegW-1:0]          r_dvs;
    logic [$clog2(MassW)-1:0] r_cnt;
    logic                     r_busy, r_done;
    logic [DegW:0]            trial;

    always_comb begin
        trial = {r_rem[DegW-1:0], r_quo[MassW-1]};
        n_quo = {r_quo[MassW-2:0], 1'b0};
        n_rem = trial;
        if (trial >= {1'b0, r_dvs}) begin
            n_rem    = trial - {1'b0, r_dvs};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == $clog2(MassW)'(MassW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

>>> design/random_walk_transition_step.sv
// Random-walk transition step: top level with sequencer and state memories.
// Load transfers write their memory as they are accepted; a read's result is held in an
// output register until taken. A step clears the next-mass memory, reads and checks each
// node in use, keeps the mass of a node of degree zero or divides it among the in-range
// neighbours, then copies all masses back. Synchronous active-low reset starts a pass
// zeroing the mass memory, input not ready until done; graph memories undefined.
module random_walk_transition_step
    import rwts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // index[12:0], data[44:13], degree[54:45]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // node[9:0], mass[41:10]
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RDWAIT, S_CLR, S_NODE_RD, S_NODE_CHK, S_DIV, S_EDGE_RD,
        S_EDGE_NB, S_EDGE_WR, S_KEEP_RD, S_KEEP_WR, S_COPY_RD, S_COPY_WR
    } t_state;

    t_state            r_state;
    logic [CountW-1:0] r_count;
    logic [NodeW-1:0]  r_node;
    logic [SlotW-1:0]  r_slot;
    logic [DegW-1:0]   r_left;
    logic [MassW-1:0]  r_share;
    logic [NodeW-1:0]  r_nbr;
    logic              r_nbr_ok;
    logic [NodeW-1:0]  r_rd_node;
    logic              r_ovalid;
    logic [NodeW-1:0]  r_onode;
    logic [MassW-1:0]  r_omass;

    logic [IndexW-1:0] in_index;
    logic [MassW-1:0]  in_data;
    logic [DegW-1:0]   in_degree;
    logic [KindW-1:0]  in_kind;
    logic              in_xfer;
    logic [CountW:0]   eff_count;
    logic              node_last;

    assign in_index  = s_axis_tdata[12:0];
    assign in_data   = s_axis_tdata[44:13];
    assign in_degree = s_axis_tdata[54:45];
    assign in_kind   = s_axis_tuser;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign eff_count = (r_count > CountW'(MaxNodes)) ? (CountW+1)'(MaxNodes)
                                                     : {1'b0, r_count};
    assign node_last = ({{(CountW+1-NodeW){1'b0}}, r_node} + 1'b1) >= eff_count;

    // RAM ports
    logic             row_we, nb_we, cur_we, nxt_we;
    logic [NodeW-1:0] row_wa, row_ra, cur_wa, cur_ra, nxt_wa, nxt_ra;
    logic [SlotW-1:0] nb_wa, nb_ra;
    logic [RowW-1:0]  row_wd, row_rd;
    logic [NodeW-1:0] nb_wd, nb_rd;
    logic [MassW-1:0] cur_wd, cur_rd, nxt_wd, nxt_rd;

    rwts_ram #(.Width(RowW), .Depth(MaxNodes)) u_row (
        .i_clk, .i_we(row_we), .i_waddr(row_wa), .i_wdata(row_wd),
        .i_raddr(row_ra), .o_rdata(row_rd));
    rwts_ram #(.Width(NodeW), .Depth(MaxEdgeSlots)) u_nbr (
        .i_clk, .i_we(nb_we), .i_waddr(nb_wa), .i_wdata(nb_wd),
        .i_raddr(nb_ra), .o_rdata(nb_rd));
    rwts_ram #(.Width(MassW), .Depth(MaxNodes)) u_cur (
        .i_clk, .i_we(cur_we), .i_waddr(cur_wa), .i_wdata(cur_wd),
        .i_raddr(cur_ra), .o_rdata(cur_rd));
    rwts_ram #(.Width(MassW), .Depth(MaxNodes)) u_nxt (
        .i_clk, .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(nxt_ra), .o_rdata(nxt_rd));

    t_div_req div_req;
    t_div_rsp div_rsp;
    rwts_div u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_rsp(div_rsp));

    // Neighbors above the node range stored as a large marker: keep high flag.
    logic             nbhi_we;
    logic             nbhi_rd;
    rwts_ram #(.Width(1), .Depth(MaxEdgeSlots)) u_nbhi (
        .i_clk, .i_we(nbhi_we), .i_waddr(nb_wa), .i_wdata(|in_data[MassW-1:NodeW]),
        .i_raddr(nb_ra), .o_rdata(nbhi_rd));

    always_comb begin
        row_we = 1'b0; row_wa = in_index[NodeW-1:0];
        row_wd = {in_data[SlotW-1:0], in_degree};
        row_ra = r_node;
        nb_we  = 1'b0; nb_wa = in_index[SlotW-1:0]; nb_wd = in_data[NodeW-1:0];
        nbhi_we = 1'b0;
        nb_ra  = r_slot;
        cur_we = 1'b0; cur_wa = in_index[NodeW-1:0]; cur_wd = in_data;
        cur_ra = (r_state == S_IDLE) ? in_index[NodeW-1:0] : r_node;
        nxt_we = 1'b0; nxt_wa = r_node; nxt_wd = '0; nxt_ra = r_node;
        div_req = '0;
        s_axis_tready = (r_state == S_IDLE) && !(r_ovalid && !m_axis_tready);
        if (in_xfer) begin
            unique case (in_kind)
                KindLoadRow:  row_we = (in_index < IndexW'(MaxNodes));
                KindLoadNbr:  begin
                    nb_we   = 1'b1;
                    nbhi_we = 1'b1;
                end
                KindLoadMass: cur_we = (in_index < IndexW'(MaxNodes));
                default: ;
            endcase
        end
        unique case (r_state)
            S_INIT: begin
                cur_we = 1'b1; cur_wa = r_node; cur_wd = '0;
            end
            S_CLR: nxt_we = 1'b1;
            S_NODE_CHK: begin
                div_req.start    = (cur_rd != '0) && (row_rd[DegW-1:0] != '0);
                div_req.dividend = cur_rd;
                div_req.divisor  = row_rd[DegW-1:0];
            end
            S_EDGE_NB: nxt_ra = nb_rd;
            S_EDGE_WR: begin
                nxt_ra = r_nbr;
                nxt_wa = r_nbr;
                nxt_we = r_nbr_ok;
                nxt_wd = sat_add(nxt_rd, r_share);
            end
            S_KEEP_WR: begin
                nxt_we = 1'b1;
                nxt_wd = sat_add(nxt_rd, r_share);
            end
            S_COPY_WR: begin
                cur_we = 1'b1; cur_wa = r_node; cur_wd = nxt_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_node   <= '0;
            r_count  <= CountW'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_count <= i_cfg_wdata;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                // Zero the whole mass memory once after reset.
                S_INIT: begin
                    if (r_node == NodeW'(MaxNodes - 1)) begin
                        r_node  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_node <= r_node + 1'b1;
                    end
                end
                S_IDLE: begin
                    r_node <= '0;
                    if (in_xfer && in_kind == KindRead &&
                        in_index < IndexW'(MaxNodes)) begin
                        r_rd_node <= in_index[NodeW-1:0];
                        r_state   <= S_RDWAIT;
                    end else if (in_xfer && in_kind == KindStep) begin
                        r_state <= S_CLR;
                    end
                end
                S_RDWAIT: begin
                    r_ovalid <= 1'b1;
                    r_onode  <= r_rd_node;
                    r_omass  <= cur_rd;
                    r_state  <= S_IDLE;
                end
                S_CLR: begin
                    if (r_node == NodeW'(MaxNodes - 1)) begin
                        r_node  <= '0;
                        r_state <= (eff_count == '0) ? S_COPY_RD : S_NODE_RD;
                    end else begin
                        r_node <= r_node + 1'b1;
                    end
                end
                S_NODE_RD: r_state <= S_NODE_CHK;
                S_NODE_CHK: begin
                    r_slot  <= row_rd[RowW-1:DegW];
                    r_left  <= row_rd[DegW-1:0];
                    r_share <= cur_rd;
                    if (cur_rd == '0) begin
                        r_state <= node_last ? S_COPY_RD : S_NODE_RD;
                        r_node  <= node_last ? '0 : r_node + 1'b1;
                    end else if (row_rd[DegW-1:0] == '0) begin
                        r_state <= S_KEEP_RD;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: if (div_rsp.done) begin
                    r_share <= div_rsp.quotient;
                    r_state <= S_EDGE_RD;
                end
                S_EDGE_RD: r_state <= S_EDGE_NB;
                S_EDGE_NB: begin
                    r_nbr    <= nb_rd;
                    r_nbr_ok <= !nbhi_rd &&
                                ({{(CountW+1-NodeW){1'b0}}, nb_rd} < eff_count);
                    r_state  <= S_EDGE_WR;
                end
                S_EDGE_WR: begin
                    r_slot <= r_slot + 1'b1;
                    r_left <= r_left - 1'b1;
                    if (r_left == DegW'(1)) begin
                        r_state <= node_last ? S_COPY_RD : S_NODE_RD;
                        r_node  <= node_last ? '0 : r_node + 1'b1;
                    end else begin
                        r_state <= S_EDGE_RD;
                    end
                end
                S_KEEP_RD: r_state <= S_KEEP_WR;
                S_KEEP_WR: begin
                    r_state <= node_last ? S_COPY_RD : S_NODE_RD;
                    r_node  <= node_last ? '0 : r_node + 1'b1;
                end
                S_COPY_RD: r_state <= S_COPY_WR;
                S_COPY_WR: begin
                    r_node  <= r_node + 1'b1;
                    r_state <= (r_node == NodeW'(MaxNodes - 1)) ? S_IDLE : S_COPY_RD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_omass, r_onode};

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_rd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RDWAIT |=> r_ovalid) else $error("read lost");
    a_div_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> r_state == S_NODE_CHK) else $error("stray divide");
    a_edge_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EDGE_WR |-> r_left != '0) else $error("edge count");
`endif
endmodule

>>> tb/sv/testbench.sv
// Testbench for random_walk_transition_step: directed and random transfers vs a predictor.
`timescale 1ns / 100ps

module testbench;
    import rwts_pkg::*;

    localparam int          HalfPeriod = 6;
    localparam int unsigned CycleLimit = 6_000_000;
    localparam logic [2:0]  KindSpare  = 3'd5;  // 5..7 are unused and ignored

    typedef struct packed {
        logic [MassW-1:0] mass;
        logic [NodeW-1:0] node;
    } t_read_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;     // index[12:0], data[44:13], degree[54:45]
    logic [2:0]  s_axis_tuser = '0;     // kind[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // node[9:0], mass[41:10]
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = '0;

    random_walk_transition_step dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #HalfPeriod i_clk = ~i_clk;

    // Predictor state: graph, masses and the node count register.
    logic [CountW-1:0] node_count_q = 11'd1;
    logic [SlotW-1:0]  row_base  [MaxNodes];
    logic [DegW-1:0]   row_deg   [MaxNodes];
    bit                row_set   [MaxNodes];
    logic [MassW-1:0]  nbr_of    [MaxEdgeSlots];
    bit                slot_set  [MaxEdgeSlots];
    logic [MassW-1:0]  mass_now  [MaxNodes];
    logic [MassW-1:0]  mass_next [MaxNodes];

    t_read_result pending_reads[$];
    int unsigned  errors = 0;
    int unsigned  cycles = 0;
    bit           quiet  = 1'b0;    // no idling on either side while set

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic int unsigned active_nodes();
        return (node_count_q > MaxNodes) ? MaxNodes : node_count_q;
    endfunction

    function automatic logic [MassW-1:0] add_clamped(input logic [MassW-1:0] a,
                                                     input logic [MassW-1:0] b);
        logic [MassW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[MassW] ? '1 : s[MassW-1:0];
    endfunction

    // One random-walk transition over the active nodes.
    function automatic void walk_once();
        int unsigned       cnt;
        logic [MassW-1:0]  share;
        logic [SlotW-1:0]  slot;
        logic [MassW-1:0]  dest;
        cnt = active_nodes();
        foreach (mass_next[v]) mass_next[v] = '0;
        for (int unsigned u = 0; u < cnt; u++) begin
            if (mass_now[u] == '0) continue;
            if (row_deg[u] == '0) begin
                mass_next[u] = add_clamped(mass_next[u], mass_now[u]);
                continue;
            end
            share = mass_now[u] / row_deg[u];
            for (int unsigned k = 0; k < row_deg[u]; k++) begin
                slot = row_base[u] + k[SlotW-1:0];     // wraps modulo the slot count
                dest = nbr_of[slot];
                if (dest < cnt) mass_next[dest] = add_clamped(mass_next[dest], share);
            end
        end
        foreach (mass_now[v]) mass_now[v] = mass_next[v];
    endfunction

    function automatic void predict_transfer(input logic [2:0] kind, input logic [12:0] idx,
                                             input logic [31:0] data, input logic [9:0] deg);
        t_read_result item;
        case (kind)
            KindLoadRow: if (idx < MaxNodes) begin
                row_base[idx] = data[SlotW-1:0];
                row_deg[idx]  = deg;
                row_set[idx]  = 1'b1;
            end
            KindLoadNbr: begin
                nbr_of[idx]   = data;
                slot_set[idx] = 1'b1;
            end
            KindLoadMass: if (idx < MaxNodes) mass_now[idx] = data;
            KindStep:     walk_once();
            KindRead:     if (idx < MaxNodes) begin
                item.node = idx[NodeW-1:0];
                item.mass = mass_now[idx];
                pending_reads.insert(pending_reads.size(), item);
            end
            default: ;
        endcase
    endfunction

    // Sends one item; blocking drives at the falling edge, acceptance seen at the rising edge.
    task automatic send(input logic [2:0] kind, input logic [31:0] idx,
                        input logic [31:0] data, input logic [31:0] deg);
        while (!quiet && $urandom_range(99) < 13) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = {1'b0, deg[DegW-1:0], data, idx[IndexW-1:0]};
        s_axis_tuser  = kind;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_transfer(kind, idx[IndexW-1:0], data, deg[DegW-1:0]);
        @(negedge i_clk);
    endtask

    // Random neighbour: mostly in range, sometimes any 32-bit value.
    function automatic logic [31:0] pick_nbr();
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range(active_nodes() > 0 ? active_nodes() - 1 : 0);
    endfunction

    // Makes sure a step never touches a row or slot that was never written;
    // rows of nodes without mass are not looked at by a step.
    task automatic complete_graph(input int unsigned max_deg);
        logic [SlotW-1:0] slot;
        for (int unsigned u = 0; u < active_nodes(); u++) begin
            if (mass_now[u] == '0) continue;
            if (!row_set[u]) send(KindLoadRow, u, $urandom, $urandom_range(max_deg));
            for (int unsigned k = 0; k < row_deg[u]; k++) begin
                slot = row_base[u] + k[SlotW-1:0];
                if (!slot_set[slot]) send(KindLoadNbr, {19'd0, slot}, pick_nbr(), $urandom);
            end
        end
    endtask

    task automatic run_step();
        complete_graph(4);
        send(KindStep, $urandom, $urandom, $urandom);
    endtask

    // A read behind any step proves the block idle once its result is in.
    task automatic drain();
        send(KindRead, 0, 0, 0);
        s_axis_tvalid = 1'b0;
        while (pending_reads.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_node_count(input logic [CountW-1:0] value);
        drain();
        i_cfg_wdata = value;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we     = 1'b0;
        node_count_q = value;
    endtask

    task automatic read_all();
        for (int unsigned u = 0; u < active_nodes(); u++) send(KindRead, u, $urandom, $urandom);
    endtask

    // Reset count of one: reads of untouched masses, out-of-range reads, unused kinds, then a step.
    task automatic test_after_reset();
        send(KindRead, 0, 32'hFFFF_FFFF, 'h3FF);
        send(KindRead, 1023, 0, 0);
        send(KindRead, 1024, 0, 0);
        send(KindRead, 'h1FFF, 0, 0);
        for (int k = KindSpare; k <= 7; k++) send(k[2:0], 0, $urandom, $urandom);
        send(KindLoadMass, 0, 32'h4000_0000, 0);
        run_step();
        send(KindRead, 0, 0, 0);
    endtask

    // Isolated node, dropped share, zero mass, saturation and wrapped rows.
    task automatic test_walk_cases();
        set_node_count(11'd4);
        send(KindLoadRow, 0, 0, 0);                 // isolated: keeps mass
        send(KindLoadRow, 1, 32'hFFFF_FFFF, 3);     // starts at last slot, wraps
        send(KindLoadRow, 2, 20, 1);
        send(KindLoadRow, 3, 30, 1);
        send(KindLoadRow, 1024, 0, 5);              // ignored
        send(KindLoadNbr, 'h1FFF, 0, 0);
        send(KindLoadNbr, 0, 2, 0);
        send(KindLoadNbr, 1, 9999, 0);              // beyond count: dropped
        send(KindLoadNbr, 20, 1, 0);
        send(KindLoadNbr, 30, 0, 0);
        send(KindLoadMass, 0, 32'hFFFF_FFFF, 0);
        send(KindLoadMass, 1, 1000, 0);
        send(KindLoadMass, 2, 0, 0);                // contributes nothing
        send(KindLoadMass, 3, 32'hFFFF_FFFF, 0);    // saturates node 0
        send(KindLoadMass, 4, 77, 0);               // beyond count: cleared
        send(KindLoadMass, 4096, 5, 0);             // ignored
        run_step();
        read_all();
        send(KindRead, 4, 0, 0);
        run_step();
        read_all();
    endtask

    task automatic test_zero_count();
        set_node_count(11'd0);
        send(KindStep, 0, 0, 0);
        send(KindRead, 0, 0, 0);
        send(KindRead, 3, 0, 0);
    endtask

    // One phase of random traffic at the given count.
    task automatic random_phase(input logic [CountW-1:0] value, input int unsigned items);
        int unsigned cnt;
        int unsigned pick;
        set_node_count(value);
        cnt = active_nodes();
        for (int unsigned u = 0; u < cnt; u++)
            if ($urandom_range(1)) send(KindLoadMass, u, $urandom >> $urandom_range(31), $urandom);
        for (int unsigned i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            if (pick < 25)
                send(KindLoadMass, ($urandom_range(9) == 0) ? $urandom : $urandom_range(cnt - 1),
                     ($urandom_range(3) == 0) ? $urandom : $urandom >> $urandom_range(31),
                     $urandom);
            else if (pick < 35)
                send(KindLoadRow, ($urandom_range(9) == 0) ? $urandom : $urandom_range(cnt - 1),
                     $urandom, $urandom_range(5));
            else if (pick < 45)
                send(KindLoadNbr, $urandom, pick_nbr(), $urandom);
            else if (pick < 80)
                send(KindRead, ($urandom_range(9) == 0) ? $urandom : $urandom_range(cnt - 1),
                     $urandom, $urandom);
            else if (pick < 95)
                run_step();
            else
                send(3'($urandom_range(7, KindSpare)), $urandom, $urandom, $urandom);
        end
        run_step();
        read_all();
    endtask

    task automatic test_random();
        quiet = 1'b1;
        random_phase(11'd8, 90);
        quiet = 1'b0;
        repeat (6) random_phase(CountW'($urandom_range(2, 24)), 90);
        random_phase(11'd1, 40);
    endtask

    // Full node range, one row of high degree, then the count beyond the maximum.
    task automatic test_full_range();
        set_node_count(11'd1024);
        send(KindLoadRow, 5, 4000, 64);
        send(KindLoadMass, 5, 32'h8000_0000, 0);
        for (int unsigned u = 0; u < 1024; u += 97)
            send(KindLoadMass, u, $urandom, $urandom);
        run_step();
        send(KindRead, 1023, 0, 0);
        for (int unsigned u = 0; u < 1024; u += 97) send(KindRead, u, 0, 0);
        set_node_count(11'd2047);
        send(KindLoadMass, 1023, 32'h0000_1000, 0);
        send(KindLoadMass, 1000, $urandom, 0);
        run_step();
        send(KindRead, 1023, 0, 0);
        send(KindRead, 1000, 0, 0);
        send(KindRead, 0, 0, 0);
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_read_result got;
        t_read_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[NodeW+MassW-1:0];
            if (pending_reads.size() == 0) begin
                report($sformatf("unexpected result node %0d mass %h", got.node, got.mass));
            end else begin
                want = pending_reads.pop_front();
                if (got.node !== want.node)
                    report($sformatf("node %0d, wanted %0d", got.node, want.node));
                if (got.mass !== want.mass)
                    report($sformatf("node %0d mass %h, wanted %h", want.node, got.mass,
                                     want.mass));
            end
        end
    end

    // Receiver stalls at random.
    always @(negedge i_clk)
        m_axis_tready = quiet || $urandom_range(99) >= 13;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        foreach (mass_now[v]) mass_now[v] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_after_reset();
        test_walk_cases();
        test_zero_count();
        test_random();
        test_full_range();
        s_axis_tvalid = 1'b0;
        while (pending_reads.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
